[src/efo_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// efo_pkg
// Shared widths, register indexes, reset values, payload structs and the
// 2^-k/256 gain table builder for the exponential fade-out block.
// ----------------------------------------------------------------------------
package efo_pkg;

  localparam int unsigned POS_W     = 31;
  localparam int unsigned SMP_W     = 16;
  localparam int unsigned GAIN_W    = 11;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned CFG_W     = 31;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PROD_W    = POS_W + CNT_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SONG_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_COUNT  = 2'd2;

  localparam logic [POS_W-1:0] SONG_LENGTH_RST = 31'(60 * 1000);
  localparam logic [POS_W-1:0] LOOP_LENGTH_RST = '0;
  localparam logic [CNT_W-1:0] LOOP_COUNT_RST  = 8'd1;

  localparam logic [POS_W-1:0]  POS_MAX    = '1;
  localparam logic [GAIN_W-1:0] UNITY_GAIN = 11'(1 << 10);

  localparam int unsigned GAIN_SHIFT     = 10;
  localparam int unsigned ROM_BASE_SHIFT = 22;
  localparam int unsigned ROM_IDX_W      = 8;
  localparam int unsigned ROM_DEPTH      = 1 << ROM_IDX_W;
  localparam int unsigned ROM_W          = 33;
  localparam int unsigned SHIFT_W        = 6;

  localparam int unsigned FADE_TIME_MS_DEF      = 5000;
  localparam int unsigned EXP_FRACTION_BITS_DEF = 8;

  typedef logic [ROM_DEPTH-1:0][ROM_W-1:0] exp_rom_t;

  typedef struct packed {
    logic [POS_W-1:0]  song_length;
    logic [PROD_W-1:0] loop_span;
  } efo_cfg_t;

  typedef struct packed {
    logic             block_end;
    logic [SMP_W-1:0] left;
    logic [SMP_W-1:0] right;
  } efo_smp_t;

  typedef struct packed {
    logic early;
    logic after;
  } efo_zone_t;

  typedef struct packed {
    logic              block_end;
    logic [SMP_W-1:0]  left;
    logic [SMP_W-1:0]  right;
    logic [GAIN_W-1:0] gain;
  } efo_res_t;

  // 2^(-2^b/256) in Q32
  function automatic logic [31:0] exp_root(input logic [2:0] b);
    logic [31:0] r;
    unique case (b)
      3'd0: r = 32'd4283353945;
      3'd1: r = 32'd4271771996;
      3'd2: r = 32'd4248701965;
      3'd3: r = 32'd4202935002;
      3'd4: r = 32'd4112874773;
      3'd5: r = 32'd3938502376;
      3'd6: r = 32'd3611622603;
      3'd7: r = 32'd3037000500;
    endcase
    return r;
  endfunction

  // Entry k is 2^(-k/256) in Q32, product of roots rounded half up each step
  function automatic exp_rom_t exp_rom_build();
    exp_rom_t               rom;
    logic [63:0]            acc;
    logic [ROM_IDX_W-1:0]   idx;
    int                     k;
    int                     b;
    rom = '0;
    for (k = 0; k < ROM_DEPTH; k++) begin
      idx = ROM_IDX_W'(k);
      acc = 64'd1 << 32;
      for (b = 0; b < ROM_IDX_W; b++) begin
        if (idx[b]) begin
          acc = (acc * {32'd0, exp_root(3'(b))} + (64'd1 << 31)) >> 32;
        end
      end
      rom[k] = acc[ROM_W-1:0];
    end
    return rom;
  endfunction

endpackage
`default_nettype wire

[src/efo_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// efo_in_if
// Request channel carrying one stereo sample pair with its position.
// ----------------------------------------------------------------------------
interface efo_in_if import efo_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position_ms;
  logic [SMP_W-1:0] left_in;
  logic [SMP_W-1:0] right_in;
  logic             block_end;

  modport source (output valid, position_ms, left_in, right_in, block_end, input ready);
  modport sink   (input valid, position_ms, left_in, right_in, block_end, output ready);
endinterface
`default_nettype wire

[src/efo_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// efo_out_if
// Result channel carrying one faded sample pair and the gain applied.
// ----------------------------------------------------------------------------
interface efo_out_if import efo_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SMP_W-1:0]  left_out;
  logic [SMP_W-1:0]  right_out;
  logic [GAIN_W-1:0] gain_used;
  logic              block_end_out;

  modport source (output valid, left_out, right_out, gain_used, block_end_out, input ready);
  modport sink   (input valid, left_out, right_out, gain_used, block_end_out, output ready);
endinterface
`default_nettype wire

[src/efo_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// efo_cfg
// Configuration registers and the registered loop span
// loop_length * (loop_count - 1), loop count zero counting as one.
// ----------------------------------------------------------------------------
module efo_cfg import efo_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output efo_cfg_t             cfg_o
);

  logic [POS_W-1:0]  song_d, song_q;
  logic [POS_W-1:0]  loop_d, loop_q;
  logic [CNT_W-1:0]  count_d, count_q;
  logic [CNT_W-1:0]  passes;
  logic [PROD_W-1:0] span_d, span_q;

  always_comb begin
    song_d  = song_q;
    loop_d  = loop_q;
    count_d = count_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SONG_LENGTH: song_d  = cfg_data_i;
        CFG_LOOP_LENGTH: loop_d  = cfg_data_i;
        CFG_LOOP_COUNT:  count_d = cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign passes = (count_q == '0) ? '0 : count_q - CNT_W'(1);
  assign span_d = PROD_W'(loop_q) * PROD_W'(passes);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      song_q  <= SONG_LENGTH_RST;
      loop_q  <= LOOP_LENGTH_RST;
      count_q <= LOOP_COUNT_RST;
      span_q  <= '0;
    end else begin
      song_q  <= song_d;
      loop_q  <= loop_d;
      count_q <= count_d;
      span_q  <= span_d;
    end
  end

  assign cfg_o.song_length = song_q;
  assign cfg_o.loop_span   = span_q;

endmodule
`default_nettype wire

[src/efo_pos.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// efo_pos
// Two stages: position relative to song length, then relative to the
// saturated fade start, giving before/after flags and the fade distance.
// ----------------------------------------------------------------------------
module efo_pos import efo_pkg::*; #(
  parameter int unsigned FADE_TIME_MS = FADE_TIME_MS_DEF,
  localparam int unsigned DIST_W      = $clog2(FADE_TIME_MS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  efo_smp_t          smp_i,
  input  logic [POS_W-1:0]  pos_i,
  input  efo_cfg_t          cfg_i,
  output logic              valid_o,
  output efo_smp_t          smp_o,
  output efo_zone_t         zone_o,
  output logic [DIST_W-1:0] dist_o
);

  localparam int unsigned REL_W  = POS_W + 2;
  localparam int unsigned DIFF_W = PROD_W + 2;
  localparam int unsigned SUM_W  = PROD_W + 1;

  logic              s2_valid_q;
  efo_smp_t          s2_smp_q;
  logic [REL_W-1:0]  s2_rel_d, s2_rel_q;
  logic              s2_pos_max_q;

  logic              s3_valid_q;
  efo_smp_t          s3_smp_q;
  efo_zone_t         s3_zone_d, s3_zone_q;
  logic [DIST_W-1:0] s3_dist_d, s3_dist_q;

  logic [SUM_W-1:0]  start_sum;
  logic              start_sat;
  logic [DIFF_W-1:0] diff;
  logic              diff_neg;

  assign s2_rel_d = {2'b00, pos_i} - {2'b00, cfg_i.song_length};

  always_comb begin
    start_sum = SUM_W'(cfg_i.song_length) + SUM_W'(cfg_i.loop_span);
    start_sat = start_sum > SUM_W'(POS_MAX);
    diff      = {{(DIFF_W-REL_W){s2_rel_q[REL_W-1]}}, s2_rel_q} - DIFF_W'(cfg_i.loop_span);
    diff_neg  = diff[DIFF_W-1];
    // fade start pinned at the top of the position range
    if (start_sat) begin
      s3_zone_d.early = !s2_pos_max_q;
      s3_zone_d.after = 1'b0;
      s3_dist_d       = '0;
    end else begin
      s3_zone_d.early = diff_neg;
      s3_zone_d.after = !diff_neg && (diff > DIFF_W'(FADE_TIME_MS));
      s3_dist_d       = diff[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q <= valid_i;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_smp_q     <= smp_i;
      s2_rel_q     <= s2_rel_d;
      s2_pos_max_q <= (pos_i == POS_MAX);
      s3_smp_q     <= s2_smp_q;
      s3_zone_q    <= s3_zone_d;
      s3_dist_q    <= s3_dist_d;
    end
  end

  assign valid_o = s3_valid_q;
  assign smp_o   = s3_smp_q;
  assign zone_o  = s3_zone_q;
  assign dist_o  = s3_dist_q;

`ifndef ASSERT_OFF
  a_zone_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> !(s3_zone_q.early && s3_zone_q.after))
    else $error("pair flagged both before and after the fade window");
`endif

endmodule
`default_nettype wire

[src/efo_gain.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// efo_gain
// Three stages: exponent 9*d*2^F/FADE_TIME by reciprocal multiply, one-step
// quotient correction, then table lookup and shift to the 11-bit gain.
// ----------------------------------------------------------------------------
module efo_gain import efo_pkg::*; #(
  parameter int unsigned FADE_TIME_MS      = FADE_TIME_MS_DEF,
  parameter int unsigned EXP_FRACTION_BITS = EXP_FRACTION_BITS_DEF,
  localparam int unsigned DIST_W           = $clog2(FADE_TIME_MS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  efo_smp_t          smp_i,
  input  efo_zone_t         zone_i,
  input  logic [DIST_W-1:0] dist_i,
  output logic              valid_o,
  output efo_smp_t          smp_o,
  output logic [GAIN_W-1:0] gain_o
);

  localparam int unsigned FRAC_W  = EXP_FRACTION_BITS;
  localparam int unsigned NUM_W   = DIST_W + 4 + FRAC_W;
  localparam int unsigned EXP_W   = FRAC_W + 4;
  localparam int unsigned MUL_W   = 2 * NUM_W + 1;
  localparam logic [63:0] RECIP_WIDE = (64'd1 << NUM_W) / 64'(FADE_TIME_MS);
  localparam logic [NUM_W:0] RECIP   = RECIP_WIDE[NUM_W:0];
  localparam exp_rom_t EXP_ROM       = exp_rom_build();

  logic              s4_valid_q;
  efo_smp_t          s4_smp_q;
  efo_zone_t         s4_zone_q;
  logic [NUM_W-1:0]  s4_num_d, s4_num_q;
  logic [EXP_W-1:0]  s4_quo_d, s4_quo_q;

  logic              s5_valid_q;
  efo_smp_t          s5_smp_q;
  efo_zone_t         s5_zone_q;
  logic [EXP_W-1:0]  s5_exp_d, s5_exp_q;

  logic              s6_valid_q;
  efo_smp_t          s6_smp_q;
  logic [GAIN_W-1:0] s6_gain_d, s6_gain_q;

  logic [DIST_W+3:0]    num9;
  logic [MUL_W-1:0]     recip_prod;
  logic [NUM_W-1:0]     quo_x_div;
  logic [NUM_W-1:0]     rem;
  logic [ROM_IDX_W-1:0] rom_idx;
  logic [3:0]           exp_int;
  logic [ROM_W-1:0]     rom_word;
  logic [ROM_W-1:0]     rom_shifted;

  // numerator and quotient estimate, low by at most one
  assign num9       = ({4'b0000, dist_i} << 3) + {4'b0000, dist_i};
  assign s4_num_d   = {num9, {FRAC_W{1'b0}}};
  assign recip_prod = MUL_W'(s4_num_d) * MUL_W'(RECIP);
  assign s4_quo_d   = recip_prod[NUM_W +: EXP_W];

  assign quo_x_div  = NUM_W'(s4_quo_q) * NUM_W'(FADE_TIME_MS);
  assign rem        = s4_num_q - quo_x_div;
  assign s5_exp_d   = (rem >= NUM_W'(FADE_TIME_MS)) ? s4_quo_q + EXP_W'(1) : s4_quo_q;

  generate
    if (EXP_FRACTION_BITS >= ROM_IDX_W) begin : g_idx_drop
      assign rom_idx = s5_exp_q[FRAC_W-1 -: ROM_IDX_W];
    end else begin : g_idx_pad
      assign rom_idx = {s5_exp_q[FRAC_W-1:0], {(ROM_IDX_W-FRAC_W){1'b0}}};
    end
  endgenerate

  assign exp_int     = s5_exp_q[EXP_W-1:FRAC_W];
  assign rom_word    = EXP_ROM[rom_idx];
  assign rom_shifted = rom_word >> (SHIFT_W'(ROM_BASE_SHIFT) + SHIFT_W'(exp_int));

  always_comb begin
    priority if (s5_zone_q.early) begin
      s6_gain_d = UNITY_GAIN;
    end else if (s5_zone_q.after) begin
      s6_gain_d = '0;
    end else begin
      s6_gain_d = rom_shifted[GAIN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
    end else if (en_i) begin
      s4_valid_q <= valid_i;
      s5_valid_q <= s4_valid_q;
      s6_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_smp_q  <= smp_i;
      s4_zone_q <= zone_i;
      s4_num_q  <= s4_num_d;
      s4_quo_q  <= s4_quo_d;
      s5_smp_q  <= s4_smp_q;
      s5_zone_q <= s4_zone_q;
      s5_exp_q  <= s5_exp_d;
      s6_smp_q  <= s5_smp_q;
      s6_gain_q <= s6_gain_d;
    end
  end

  assign valid_o = s6_valid_q;
  assign smp_o   = s6_smp_q;
  assign gain_o  = s6_gain_q;

`ifndef ASSERT_OFF
  localparam logic [GAIN_W-1:0] WINDOW_GAIN_MIN = 11'(1 << 10) >> 9;

  a_window_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && s5_valid_q && !s5_zone_q.early && !s5_zone_q.after
    |=> s6_gain_q >= WINDOW_GAIN_MIN && s6_gain_q <= UNITY_GAIN)
    else $error("gain inside the fade window out of range");
`endif

endmodule
`default_nettype wire

[src/efo_scale.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// efo_scale
// Output stage: both samples times the gain, arithmetic shift right by 10,
// held in the output register until taken.
// ----------------------------------------------------------------------------
module efo_scale import efo_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  efo_smp_t          smp_i,
  input  logic [GAIN_W-1:0] gain_i,
  output logic              valid_o,
  output efo_res_t          res_o
);

  localparam int unsigned MUL_W = SMP_W + GAIN_W + 1;

  logic signed [MUL_W-1:0] left_prod;
  logic signed [MUL_W-1:0] right_prod;
  logic                    valid_q;
  efo_res_t                res_d, res_q;

  assign left_prod  = $signed(smp_i.left) * $signed({1'b0, gain_i});
  assign right_prod = $signed(smp_i.right) * $signed({1'b0, gain_i});

  always_comb begin
    res_d.block_end = smp_i.block_end;
    res_d.left      = left_prod[GAIN_SHIFT +: SMP_W];
    res_d.right     = right_prod[GAIN_SHIFT +: SMP_W];
    res_d.gain      = gain_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

`ifndef ASSERT_OFF
  a_unity_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && valid_i && gain_i == UNITY_GAIN
    |=> res_q.left == $past(smp_i.left) && res_q.right == $past(smp_i.right))
    else $error("unity gain altered a sample");

  a_zero_mutes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && valid_i && gain_i == '0 |=> res_q.left == '0 && res_q.right == '0)
    else $error("zero gain left a non-zero sample");

  a_gain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> res_q.gain <= UNITY_GAIN)
    else $error("gain above unity at the output");
`endif

endmodule
`default_nettype wire

[src/exponential_audio_fade_out.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// exponential_audio_fade_out
// Stereo fade-out: scales each sample pair by an exponential gain that
// falls from unity to 1/512 over FADE_TIME_MS after the fade start.
// ----------------------------------------------------------------------------
// One sample pair is taken every cycle while the output is not held back;
// its result passes through the seven register stages (input register,
// two stages of fade-start compare, reciprocal multiply, quotient correction,
// table lookup, and the output multiply register). When the output is not
// taken the whole pipeline holds, so input ready follows output ready.
// The fade start is song_length + loop_length * (loop_count - 1), saturated
// at the position range; write the registers only while no pair is in
// flight.
module exponential_audio_fade_out import efo_pkg::*; #(
  parameter int unsigned FADE_TIME_MS      = FADE_TIME_MS_DEF,
  parameter int unsigned EXP_FRACTION_BITS = EXP_FRACTION_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  efo_in_if.sink               in_ch,
  efo_out_if.source            out_ch
);

  localparam int unsigned DIST_W = $clog2(FADE_TIME_MS + 1);

  efo_cfg_t          cfg;
  logic              en;
  logic              s1_valid_q;
  efo_smp_t          s1_smp_d, s1_smp_q;
  logic [POS_W-1:0]  s1_pos_q;

  logic              pos_valid;
  efo_smp_t          pos_smp;
  efo_zone_t         pos_zone;
  logic [DIST_W-1:0] pos_dist;

  logic              gain_valid;
  efo_smp_t          gain_smp;
  logic [GAIN_W-1:0] gain;

  logic              res_valid;
  efo_res_t          res;

  // advance everything whenever the output register is free or being taken
  assign en          = !res_valid || out_ch.ready;
  assign in_ch.ready = en;

  assign s1_smp_d.block_end = in_ch.block_end;
  assign s1_smp_d.left      = in_ch.left_in;
  assign s1_smp_d.right     = in_ch.right_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_smp_q <= s1_smp_d;
      s1_pos_q <= in_ch.position_ms;
    end
  end

  efo_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  efo_pos #(
    .FADE_TIME_MS (FADE_TIME_MS)
  ) u_pos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_valid_q),
    .smp_i   (s1_smp_q),
    .pos_i   (s1_pos_q),
    .cfg_i   (cfg),
    .valid_o (pos_valid),
    .smp_o   (pos_smp),
    .zone_o  (pos_zone),
    .dist_o  (pos_dist)
  );

  efo_gain #(
    .FADE_TIME_MS      (FADE_TIME_MS),
    .EXP_FRACTION_BITS (EXP_FRACTION_BITS)
  ) u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pos_valid),
    .smp_i   (pos_smp),
    .zone_i  (pos_zone),
    .dist_i  (pos_dist),
    .valid_o (gain_valid),
    .smp_o   (gain_smp),
    .gain_o  (gain)
  );

  efo_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (gain_valid),
    .smp_i   (gain_smp),
    .gain_i  (gain),
    .valid_o (res_valid),
    .res_o   (res)
  );

  assign out_ch.valid         = res_valid;
  assign out_ch.left_out      = res.left;
  assign out_ch.right_out     = res.right;
  assign out_ch.gain_used     = res.gain;
  assign out_ch.block_end_out = res.block_end;

endmodule
`default_nettype wire

[tb/sv/exponential_audio_fade_out_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// exponential_audio_fade_out_tb
// Self-checking bench for the stereo fade-out stage. A local model of the
// fade start, the 2^-k/256 gain table and the sample scaling predicts every
// faded pair. Requests and results move with random gaps on both channels.
// Directed edge cases run first, then random phases under varied register
// settings, then a long output hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module exponential_audio_fade_out_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import efo_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam int FADE_MS         = FADE_TIME_MS_DEF;
  localparam int FRAC_BITS       = EXP_FRACTION_BITS_DEF;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT     = 4000;
  localparam int MAX_REPORTS     = 10;
  localparam int RANDOM_PHASES   = 6;
  localparam int PHASE_PAIRS     = 190;
  localparam int BURST_PAIRS     = 40;
  localparam int SETTLE_CYCLES   = 12;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [SMP_W-1:0] left;
    logic [SMP_W-1:0] right;
    logic             blk;
  } pair_req_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  efo_in_if  in_ch ();
  efo_out_if out_ch ();

  exponential_audio_fade_out #(
    .FADE_TIME_MS      (FADE_MS),
    .EXP_FRACTION_BITS (FRAC_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // Local copy of the registers and the gain table
  logic [POS_W-1:0] song_ms;
  logic [POS_W-1:0] loop_ms;
  logic [CNT_W-1:0] loop_cnt;
  logic [32:0]      gain_lut [ROM_DEPTH];

  efo_res_t faded_q [$];
  int       mismatch_cnt = 0;
  bit       tx_steady    = 1'b0;
  bit       hold_off_req = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [31:0] half_root(input int b);
    case (b)
      0:       return 32'd4283353945;
      1:       return 32'd4271771996;
      2:       return 32'd4248701965;
      3:       return 32'd4202935002;
      4:       return 32'd4112874773;
      5:       return 32'd3938502376;
      6:       return 32'd3611622603;
      default: return 32'd3037000500;
    endcase
  endfunction

  function automatic logic [32:0] lut_entry(input int k);
    logic [63:0] acc;
    acc = 64'd1 << 32;
    for (int b = 0; b < ROM_IDX_W; b++) begin
      if (k[b]) begin
        acc = (acc * {32'd0, half_root(b)} + (64'd1 << 31)) >> 32;
      end
    end
    return acc[32:0];
  endfunction

  function automatic logic [63:0] fade_start_ms();
    logic [63:0] passes;
    logic [63:0] sum;
    passes = (loop_cnt != '0) ? 64'(loop_cnt) - 64'd1 : 64'd0;
    sum    = 64'(song_ms) + 64'(loop_ms) * passes;
    return (sum > 64'(POS_MAX)) ? 64'(POS_MAX) : sum;
  endfunction

  function automatic logic [GAIN_W-1:0] fade_gain_at(input logic [POS_W-1:0] pos);
    logic [63:0] start;
    logic [63:0] d;
    logic [63:0] e;
    logic [63:0] ipart;
    logic [63:0] fpart;
    logic [63:0] k;
    start = fade_start_ms();
    if (64'(pos) < start) return UNITY_GAIN;
    if (64'(pos) > start + 64'(FADE_MS)) return '0;
    d     = 64'(pos) - start;
    e     = ((64'd9 * d) << FRAC_BITS) / 64'(FADE_MS);
    ipart = e >> FRAC_BITS;
    fpart = e & ((64'd1 << FRAC_BITS) - 64'd1);
    if (FRAC_BITS >= ROM_IDX_W) k = fpart >> (FRAC_BITS - ROM_IDX_W);
    else                        k = fpart << (ROM_IDX_W - FRAC_BITS);
    k = k & 64'hFF;
    if (ipart > 64'd31) return '0;
    return GAIN_W'(gain_lut[k[7:0]] >> (ROM_BASE_SHIFT + ipart));
  endfunction

  // floor(s * g / 1024): arithmetic shift of the signed product
  function automatic logic [SMP_W-1:0] scale_by(input logic [SMP_W-1:0] s,
                                                 input logic [GAIN_W-1:0] g);
    logic signed [31:0] sw;
    logic signed [31:0] gw;
    logic signed [31:0] p;
    sw = {{16{s[SMP_W-1]}}, s};
    gw = {21'd0, g};
    p  = (sw * gw) >>> GAIN_SHIFT;
    return p[SMP_W-1:0];
  endfunction

  function automatic efo_res_t fade_pair(input pair_req_t r);
    efo_res_t res;
    res.gain      = fade_gain_at(r.pos);
    res.left      = scale_by(r.left, res.gain);
    res.right     = scale_by(r.right, res.gain);
    res.block_end = r.blk;
    return res;
  endfunction

  // ---------------------------------------------------------------- random

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_run();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(1, 4);
    if (r < 85) return $urandom_range(5, 20);
    return $urandom_range(50, 150);
  endfunction

  function automatic logic [SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 24))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] rand_full_pos();
    return POS_W'($urandom);
  endfunction

  // Cluster positions on the fade window, with a share spread over the range
  function automatic logic [POS_W-1:0] rand_position();
    longint start;
    longint cand;
    int     sel;
    start = longint'(fade_start_ms());
    sel   = $urandom_range(0, 99);
    if (sel < 10) return rand_full_pos();
    if (sel < 16) begin
      case ($urandom_range(0, 3))
        0:       cand = start - 1;
        1:       cand = start;
        2:       cand = start + FADE_MS;
        default: cand = start + FADE_MS + 1;
      endcase
    end else begin
      cand = start + longint'($urandom_range(0, FADE_MS + 400)) - 200;
    end
    if (cand < 0 || cand > longint'(POS_MAX)) return rand_full_pos();
    return POS_W'(cand);
  endfunction

  function automatic pair_req_t mk_pair(input logic [POS_W-1:0] pos,
                                        input logic [SMP_W-1:0] l,
                                        input logic [SMP_W-1:0] r,
                                        input logic b);
    pair_req_t p;
    p.pos   = pos;
    p.left  = l;
    p.right = r;
    p.blk   = b;
    return p;
  endfunction

  function automatic pair_req_t rand_pair();
    return mk_pair(rand_position(), rand_sample(), rand_sample(), 1'($urandom));
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic offer_pair(input pair_req_t r);
    in_ch.valid       = 1'b1;
    in_ch.position_ms = r.pos;
    in_ch.left_in     = r.left;
    in_ch.right_in    = r.right;
    in_ch.block_end   = r.blk;
    do @(posedge clk_i); while (!in_ch.ready);
    faded_q.push_back(fade_pair(r));
    @(negedge clk_i);
  endtask

  task automatic stream_pair(input pair_req_t r);
    int gap;
    offer_pair(r);
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Hold the sender until every faded pair is back, then let the pipe settle
  task automatic drain();
    in_ch.valid = 1'b0;
    while (faded_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_SONG_LENGTH: song_ms  = data;
      CFG_LOOP_LENGTH: loop_ms  = data;
      CFG_LOOP_COUNT:  loop_cnt = data[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_fade(input logic [POS_W-1:0] song, input logic [POS_W-1:0] loop_len,
                          input logic [CNT_W-1:0] cnt);
    drain();
    write_reg(CFG_SONG_LENGTH, song);
    write_reg(CFG_LOOP_LENGTH, loop_len);
    write_reg(CFG_LOOP_COUNT, CFG_W'(cnt));
  endtask

  // ---------------------------------------------------------------- tests

  // Reset settings: fade from 60 s over the default window
  task automatic test_reset_fade();
    stream_pair(mk_pair(31'd0,     16'h7FFF, 16'h8000, 1'b0));
    stream_pair(mk_pair(31'd59999, 16'h8000, 16'h7FFF, 1'b1));
    stream_pair(mk_pair(31'd60000, 16'h7FFF, 16'h8000, 1'b1));
    stream_pair(mk_pair(31'd60001, 16'h1234, 16'hFFFF, 1'b0));
    stream_pair(mk_pair(31'd62500, 16'h7FFF, 16'h8000, 1'b1));
    stream_pair(mk_pair(31'd64999, 16'h0001, 16'hFFFF, 1'b0));
    stream_pair(mk_pair(31'd65000, 16'h7FFF, 16'h8000, 1'b0));
    stream_pair(mk_pair(31'd65001, 16'h7FFF, 16'h8000, 1'b1));
    stream_pair(mk_pair(POS_MAX,   16'hFFFF, 16'h0001, 1'b0));
  endtask

  task automatic test_register_writes();
    set_fade(31'd1000, 31'd500, 8'd3);
    stream_pair(mk_pair(31'd1999, rand_sample(), rand_sample(), 1'b0));
    stream_pair(mk_pair(31'd2000, rand_sample(), rand_sample(), 1'b1));
    stream_pair(mk_pair(31'd4321, rand_sample(), rand_sample(), 1'b0));
    stream_pair(mk_pair(31'd7000, rand_sample(), rand_sample(), 1'b1));
    stream_pair(mk_pair(31'd7001, rand_sample(), rand_sample(), 1'b0));
    // zero loop count behaves as one pass
    set_fade(31'd1000, 31'd500, 8'd0);
    stream_pair(mk_pair(31'd999,  rand_sample(), rand_sample(), 1'b1));
    stream_pair(mk_pair(31'd1000, rand_sample(), rand_sample(), 1'b0));
    stream_pair(mk_pair(31'd6000, rand_sample(), rand_sample(), 1'b1));
    // write to the unused index must leave the fade untouched
    drain();
    write_reg(CFG_SPARE, CFG_W'($urandom));
    stream_pair(mk_pair(31'd3500, rand_sample(), rand_sample(), 1'b0));
    // fade start saturates at the top of the position range
    set_fade(POS_MAX - 31'd100, POS_MAX, 8'd255);
    stream_pair(mk_pair(POS_MAX - 31'd1, rand_sample(), rand_sample(), 1'b1));
    stream_pair(mk_pair(POS_MAX,         rand_sample(), rand_sample(), 1'b0));
    set_fade(31'd0, 31'd0, 8'd1);
    stream_pair(mk_pair(31'd0,    rand_sample(), rand_sample(), 1'b1));
    stream_pair(mk_pair(31'd5000, rand_sample(), rand_sample(), 1'b0));
    stream_pair(mk_pair(31'd5001, rand_sample(), rand_sample(), 1'b1));
  endtask

  function automatic logic [POS_W-1:0] rand_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 15) return POS_MAX;
    if (r < 55) return POS_W'($urandom_range(0, 200000));
    return rand_full_pos();
  endfunction

  function automatic logic [CNT_W-1:0] rand_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'd0;
    if (r < 30) return 8'd255;
    if (r < 70) return CNT_W'($urandom_range(1, 4));
    return CNT_W'($urandom_range(1, 255));
  endfunction

  task automatic test_random_phases();
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) set_fade('0, '0, 8'd1);
      else if (ph == RANDOM_PHASES - 1) set_fade(POS_MAX, POS_MAX, 8'd255);
      else set_fade(rand_length(), rand_length(), rand_count());
      tx_steady = (ph == 2);
      for (int n = 0; n < PHASE_PAIRS; n++) begin
        stream_pair(rand_pair());
      end
    end
    tx_steady = 1'b0;
  endtask

  // Hold off the result side while requests keep coming, so the pipe fills
  task automatic test_output_hold_off();
    set_fade(POS_W'($urandom_range(0, 100000)), POS_W'($urandom_range(0, 1000)),
             CNT_W'($urandom_range(1, 8)));
    hold_off_req = 1'b1;
    tx_steady    = 1'b1;
    for (int n = 0; n < BURST_PAIRS; n++) begin
      stream_pair(rand_pair());
    end
    tx_steady = 1'b0;
    drain();
  endtask

  // ---------------------------------------------------------------- processes

  // Result side: random ready with runs, gaps and one long hold-off on request
  initial begin : result_ready
    int run_left;
    int gap_left;
    int hold_left;
    run_left     = 0;
    gap_left     = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_left    = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        out_ch.ready = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ch.ready = 1'b0;
      end else begin
        run_left     = pick_run();
        gap_left     = pick_gap();
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    efo_res_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (faded_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
          $display("unexpected result: left %h right %h gain %0d end %b",
                   out_ch.left_out, out_ch.right_out, out_ch.gain_used,
                   out_ch.block_end_out);
        end
      end else begin
        want = faded_q.pop_front();
        if (out_ch.left_out !== want.left || out_ch.right_out !== want.right ||
            out_ch.gain_used !== want.gain || out_ch.block_end_out !== want.block_end) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("mismatch at %0t: left %h/%h right %h/%h gain %0d/%0d end %b/%b",
                     $realtime, want.left, out_ch.left_out, want.right, out_ch.right_out,
                     want.gain, out_ch.gain_used, want.block_end, out_ch.block_end_out);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int stall_cnt;
    stall_cnt = 0;
    while (stall_cnt < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cnt = 0;
      end else begin
        stall_cnt++;
      end
    end
    $display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : main_seq
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_SONG_LENGTH;
    cfg_data_i        = '0;
    in_ch.valid       = 1'b0;
    in_ch.position_ms = '0;
    in_ch.left_in     = '0;
    in_ch.right_in    = '0;
    in_ch.block_end   = 1'b0;
    song_ms           = SONG_LENGTH_RST;
    loop_ms           = LOOP_LENGTH_RST;
    loop_cnt          = LOOP_COUNT_RST;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      gain_lut[k] = lut_entry(k);
    end
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_fade();
    test_register_writes();
    test_random_phases();
    test_output_hold_off();
    drain();

    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
